// ----- rtl/core/cen_pkg.sv -----
// shared types and constants for the census transform window core
package cen_pkg;

	localparam int PIX_W      = 8;
	localparam int CENSUS_W   = 63;
	localparam int ROW_W      = 12;
	localparam int COL_OUT_W  = 10;
	localparam int HW_W       = 3;
	localparam int HH_W       = 2;
	localparam int IW_W       = 11;
	localparam int IH_W       = 13;
	localparam int MAX_HEIGHT = 4096;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int OUT_DATA_W = 88;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HALF_W = 4;
	localparam int DEF_MAX_HALF_H = 3;

	typedef logic [PIX_W-1:0] pix_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HALF_WIDTH,
		CFG_HALF_HEIGHT,
		CFG_IMAGE_WIDTH,
		CFG_IMAGE_HEIGHT
	} cfg_reg_t;

	// per-pixel bookkeeping that follows a word down the pipe
	typedef struct packed {
		logic                 emit;
		logic                 last;
		logic [ROW_W-1:0]     row;
		logic [COL_OUT_W-1:0] col;
	} meta_t;

	// control shared by every window cell
	typedef struct packed {
		logic shift;
		logic capture;
		pix_t centre;
	} cell_ctl_t;

endpackage

// ----- rtl/core/census_transform_window_core.sv -----
// top level: line buffers, window cell chain, census packing and stream ports
// throughput: one pixel word per cycle unless the output stalls, no gaps at row or frame ends
// path: the census word of a centre reaches the output register after the pixel that
// completes its window is accepted, through line ram read, window shift, compare and pack
// reset: counters and pipe valids clear at once, config returns to its defaults;
// line rams are not cleared, no clearing pass, first word can be taken right after reset
module census_transform_window_core #(
	parameter int MAX_WIDTH  = cen_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HALF_W = cen_pkg::DEF_MAX_HALF_W,
	parameter int MAX_HALF_H = cen_pkg::DEF_MAX_HALF_H
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// pixel stream in
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [cen_pkg::PIX_W-1:0]         s_axis_tdata,  // [7:0] pixel
	// census stream out
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [62:0] census, [74:63] centre_row, [84:75] centre_column, [87:85] zero
	output logic [cen_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	output logic                              m_axis_tlast,  // last_of_frame
	// register writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cen_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cen_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import cen_pkg::*;

	localparam int WIN_COLS = 2 * MAX_HALF_W + 1;
	localparam int LINES    = 2 * MAX_HALF_H;
	localparam int WIN_ROWS = LINES + 1;
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int LP_W     = $clog2(LINES);

	// ---------------- configuration registers ----------------
	logic [HW_W-1:0] half_width_q;
	logic [HH_W-1:0] half_height_q;
	logic [IW_W-1:0] image_width_q;
	logic [IH_W-1:0] image_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q   <= HW_W'(1);
			half_height_q  <= HH_W'(1);
			image_width_q  <= IW_W'(640);
			image_height_q <= IH_W'(480);
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_HALF_WIDTH:   half_width_q   <= cfg_data[HW_W-1:0];
				CFG_HALF_HEIGHT:  half_height_q  <= cfg_data[HH_W-1:0];
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data[IW_W-1:0];
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data[IH_W-1:0];
			endcase
		end
	end

	// clamp the registers into what the hardware holds
	logic [HW_W-1:0] m_sat;
	logic [HH_W-1:0] n_sat;
	logic [IH_W-1:0] w_eff;
	logic [IH_W-1:0] h_eff;

	always_comb begin
		m_sat = (half_width_q > HW_W'(MAX_HALF_W)) ? HW_W'(MAX_HALF_W) : half_width_q;
		n_sat = (half_height_q > HH_W'(MAX_HALF_H)) ? HH_W'(MAX_HALF_H) : half_height_q;
		w_eff = (image_width_q == '0) ? IH_W'(1) : IH_W'(image_width_q);
		if (w_eff > IH_W'(MAX_WIDTH)) begin
			w_eff = IH_W'(MAX_WIDTH);
		end
		h_eff = (image_height_q == '0) ? IH_W'(1) : image_height_q;
		if (h_eff > IH_W'(MAX_HEIGHT)) begin
			h_eff = IH_W'(MAX_HEIGHT);
		end
	end

	// ---------------- pipe handshake ----------------
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready_s1, ready_s2, ready_s3, ready_s4;
	logic in_acc, shift_en, cap_en, load_s4;

	assign ready_s4 = !valid_s4 || m_axis_tready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;

	assign s_axis_tready = ready_s1;
	assign in_acc        = s_axis_tvalid && ready_s1;
	assign shift_en      = valid_s1 && ready_s2;   // every pixel moves the window
	assign cap_en        = valid_s2 && ready_s3;
	assign load_s4       = valid_s3 && ready_s4;

	// ---------------- raster counters ----------------
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [LP_W-1:0]  line_ptr_q;   // line ram that holds row_q, i.e. row mod LINES
	logic             row_end;
	logic             frame_end;
	meta_t            meta_s0;

	assign row_end   = (IH_W'(col_q) + IH_W'(1)) >= w_eff;
	assign frame_end = (IH_W'(row_q) + IH_W'(1)) >= h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			line_ptr_q <= '0;
		end else if (in_acc) begin
			if (row_end) begin
				col_q <= '0;
				if (frame_end) begin
					row_q      <= '0;
					line_ptr_q <= '0;
				end else begin
					row_q      <= row_q + ROW_W'(1);
					line_ptr_q <= (line_ptr_q == LP_W'(LINES - 1)) ? '0 : line_ptr_q + LP_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// the accepted pixel completes the window of centre (row - n, col - m)
	always_comb begin
		meta_s0.emit = (row_q >= ROW_W'({n_sat, 1'b0})) && (col_q >= COL_W'({m_sat, 1'b0}));
		meta_s0.last = (IH_W'(row_q) == h_eff - IH_W'(1)) && (IH_W'(col_q) == w_eff - IH_W'(1));
		meta_s0.row  = row_q - ROW_W'(n_sat);
		meta_s0.col  = COL_OUT_W'(col_q - COL_W'(m_sat));
	end

	// ---------------- line buffers ----------------
	pix_t rd_line [LINES];

	for (genvar l = 0; l < LINES; l++) begin : g_line
		cen_line_ram #(
			.DEPTH (MAX_WIDTH),
			.AW    (COL_W)
		) u_line_ram (
			.clk   (clk),
			.en    (in_acc),
			.we    (line_ptr_q == LP_W'(l)),
			.addr  (col_q),
			.wdata (s_axis_tdata),
			.rdata (rd_line[l])
		);
	end

	// ---------------- stage 1: line data arrives ----------------
	pix_t            pix_s1;
	logic [LP_W-1:0] line_ptr_s1;
	meta_t           meta_s1;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1      <= s_axis_tdata;
			line_ptr_s1 <= line_ptr_q;
			meta_s1     <= meta_s0;
		end
	end

	// rotate lines so window row k holds image row (current - LINES + k)
	pix_t [WIN_ROWS-1:0] new_col;

	always_comb begin
		logic [LP_W:0] sel;
		sel = '0;
		for (int k = 0; k < LINES; k++) begin
			sel = {1'b0, line_ptr_s1} + (LP_W + 1)'(k);
			if (sel >= (LP_W + 1)'(LINES)) begin
				sel = sel - (LP_W + 1)'(LINES);
			end
			new_col[k] = rd_line[sel[LP_W-1:0]];
		end
		new_col[LINES] = pix_s1;
	end

	// ---------------- stage 2/3: window cell chain ----------------
	pix_t [WIN_ROWS-1:0] win_col [WIN_COLS];
	logic [WIN_ROWS-1:0] cmp_col [WIN_COLS];
	cell_ctl_t           cell_ctl;
	pix_t                centre;
	meta_t               meta_s2;
	meta_t               meta_s3;

	// centre sits at window row LINES - n, column WIN_COLS - 1 - m
	always_comb begin
		centre = '0;
		for (int nn = 0; nn <= MAX_HALF_H; nn++) begin
			for (int mm = 0; mm <= MAX_HALF_W; mm++) begin
				if (n_sat == HH_W'(nn) && m_sat == HW_W'(mm)) begin
					centre = win_col[WIN_COLS-1-mm][LINES-nn];
				end
			end
		end
	end

	assign cell_ctl.shift   = shift_en;
	assign cell_ctl.capture = cap_en;
	assign cell_ctl.centre  = centre;

	// newest column enters at the right end and walks left one cell per pixel
	for (genvar q = 0; q < WIN_COLS; q++) begin : g_cell
		if (q == WIN_COLS - 1) begin : g_head
			cen_cell #(.ROWS(WIN_ROWS)) u_cell (
				.clk    (clk),
				.ctl    (cell_ctl),
				.col_in (new_col),
				.col_q  (win_col[q]),
				.cmp_s3 (cmp_col[q])
			);
		end else begin : g_body
			cen_cell #(.ROWS(WIN_ROWS)) u_cell (
				.clk    (clk),
				.ctl    (cell_ctl),
				.col_in (win_col[q+1]),
				.col_q  (win_col[q]),
				.cmp_s3 (cmp_col[q])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			meta_s2 <= meta_s1;
		end
		if (cap_en) begin
			meta_s3 <= meta_s2;
		end
	end

	// ---------------- stage 4: pack census bits, output register ----------------
	logic [CENSUS_W-1:0]  census_d;
	logic [CENSUS_W-1:0]  census_s4;
	logic [ROW_W-1:0]     crow_s4;
	logic [COL_OUT_W-1:0] ccol_s4;
	logic                 last_s4;

	// row-major over the active (2n+1) x (2m+1) corner of the window
	always_comb begin
		int bit_idx;
		census_d = '0;
		bit_idx  = 0;
		for (int nn = 0; nn <= MAX_HALF_H; nn++) begin
			for (int mm = 0; mm <= MAX_HALF_W; mm++) begin
				if (n_sat == HH_W'(nn) && m_sat == HW_W'(mm)) begin
					for (int i = 0; i <= 2 * nn; i++) begin
						for (int j = 0; j <= 2 * mm; j++) begin
							bit_idx = i * (2 * mm + 1) + j;
							if (bit_idx < CENSUS_W) begin
								census_d[bit_idx] =
									cmp_col[WIN_COLS-1-2*mm+j][LINES-2*nn+i];
							end
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s4) begin
			census_s4 <= census_d;
			crow_s4   <= meta_s3.row;
			ccol_s4   <= meta_s3.col;
			last_s4   <= meta_s3.last;
		end
	end

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			// border pixels shift the window but carry no word further
			if (ready_s2) begin
				valid_s2 <= valid_s1 && meta_s1.emit;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	assign m_axis_tvalid = valid_s4;
	assign m_axis_tlast  = last_s4;
	assign m_axis_tdata  = {(OUT_DATA_W - CENSUS_W - ROW_W - COL_OUT_W)'(0),
		ccol_s4, crow_s4, census_s4};

endmodule

// ----- rtl/core/cen_line_ram.sv -----
// one line buffer: single write port, registered read, read returns old data
module cen_line_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          en,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  cen_pkg::pix_t wdata,
	output cen_pkg::pix_t rdata
);
	import cen_pkg::*;

	pix_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end
			rdata <= mem_q[addr];
		end
	end

endmodule

// ----- rtl/core/cen_cell.sv -----
// one window column: holds its pixels, passes them left, compares against the centre
module cen_cell #(
	parameter int ROWS = 7
) (
	input  logic                      clk,
	input  cen_pkg::cell_ctl_t        ctl,
	input  cen_pkg::pix_t [ROWS-1:0]  col_in,
	output cen_pkg::pix_t [ROWS-1:0]  col_q,
	output logic [ROWS-1:0]           cmp_s3
);
	import cen_pkg::*;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			col_q <= col_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			for (int k = 0; k < ROWS; k++) begin
				cmp_s3[k] <= (ctl.centre < col_q[k]);
			end
		end
	end

endmodule
